FILE: rtl/core/tbo_pkg.sv
// ----------------------------------------------------------------------------
// tbo_pkg: shared definitions for the triangle / box overlap test
// Register indexes, ring index tables and the fixed-width multiply helpers
// used by the pipeline stages.
// ----------------------------------------------------------------------------
package tbo_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_CX = 3'd0;
	localparam logic [2:0] REG_CY = 3'd1;
	localparam logic [2:0] REG_CZ = 3'd2;
	localparam logic [2:0] REG_HX = 3'd3;
	localparam logic [2:0] REG_HY = 3'd4;
	localparam logic [2:0] REG_HZ = 3'd5;

	// next and previous index around a ring of three (vertices or axes)
	localparam int NXT [3] = '{1, 2, 0};
	localparam int PRV [3] = '{2, 0, 1};

	// edge component times box-local vertex component
	function automatic logic signed [66:0] mul_fv(logic signed [32:0] a,
		logic signed [33:0] b);
		logic signed [66:0] r;
		r = a * b;
		return r;
	endfunction

	// edge component times edge component
	function automatic logic signed [65:0] mul_ff(logic signed [32:0] a,
		logic signed [32:0] b);
		logic signed [65:0] r;
		r = a * b;
		return r;
	endfunction

	// normal slice times box-local vertex component
	function automatic logic signed [67:0] mul_nv(logic signed [33:0] a,
		logic signed [33:0] b);
		logic signed [67:0] r;
		r = a * b;
		return r;
	endfunction

	// half extent times axis magnitude or magnitude slice
	function automatic logic [63:0] mul_hm(logic [30:0] h, logic [32:0] m);
		logic [63:0] r;
		r = 64'(h) * 64'(m);
		return r;
	endfunction

endpackage

FILE: rtl/core/triangle_box_overlap_test.sv
// ----------------------------------------------------------------------------
// triangle_box_overlap_test: separating axis test of a triangle against a box
//
// Usage: the box (center, half extents, Q16.16) is loaded through the write
// port wr_en / wr_idx / wr_data while no triangle is in flight. A triangle
// word (three vertices plus an offset) is taken at every rising edge with
// start high; busy is always low, so one word can be taken every cycle.
// Each word yields one result word: done pulses for one cycle with overlap
// valid in that cycle. Result words come out in order, through the seven
// register stages below; the receiver cannot stall and none is needed.
// The seven register stages: box-local vertices and edges, edge and normal
// products, edge projections and normal, edge compare plus normal partial
// products, normal product assembly, normal dot sums, final compare. The
// normal path sets the depth; its dot products use 34-bit slices.
// Reset clears the box registers to zero and drops all in-flight words.
// ----------------------------------------------------------------------------
module triangle_box_overlap_test (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic signed [31:0] v0_x,
	input  logic signed [31:0] v0_y,
	input  logic signed [31:0] v0_z,
	input  logic signed [31:0] v1_x,
	input  logic signed [31:0] v1_y,
	input  logic signed [31:0] v1_z,
	input  logic signed [31:0] v2_x,
	input  logic signed [31:0] v2_y,
	input  logic signed [31:0] v2_z,
	input  logic signed [31:0] offset_x,
	input  logic signed [31:0] offset_y,
	input  logic signed [31:0] offset_z,
	input  logic               wr_en,
	input  logic [2:0]         wr_idx,
	input  logic [31:0]        wr_data,
	output logic               overlap
);

	// box registers
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic [30:0]        hx_q, hy_q, hz_q;
	logic signed [31:0] ctr [3];
	logic [30:0]        hlf [3];
	logic signed [31:0] vin [3][3];
	logic signed [31:0] off [3];
	logic               accept;

	// stage 1
	logic               vld_s1;
	logic signed [33:0] v_d [3][3], v_s1 [3][3];
	logic signed [32:0] f_d [3][3], f_s1 [3][3];
	logic [32:0]        fa_d [3][3], fa_s1 [3][3];
	// stage 2
	logic               vld_s2, face_d, face_s2;
	logic signed [33:0] v_s2 [3][3];
	logic signed [66:0] pa_d [3][3][2], pa_s2 [3][3][2];
	logic signed [66:0] pb_d [3][3][2], pb_s2 [3][3][2];
	logic [63:0]        ra_d [3][3], ra_s2 [3][3];
	logic [63:0]        rb_d [3][3], rb_s2 [3][3];
	logic signed [65:0] nm_d [3][2], nm_s2 [3][2];
	// stage 3
	logic               vld_s3, face_s3;
	logic signed [33:0] v_s3 [3][3];
	logic signed [67:0] ep_d [3][3][2], ep_s3 [3][3][2];
	logic [64:0]        er_d [3][3], er_s3 [3][3];
	logic signed [66:0] n_d [3], n_s3 [3];
	logic [65:0]        na_d [3], na_s3 [3];
	// stage 4
	logic               vld_s4, sep_d, sep_s4;
	logic signed [67:0] ql_d [3][3], ql_s4 [3][3];
	logic signed [67:0] qh_d [3][3], qh_s4 [3][3];
	logic [63:0]        rl_d [3], rl_s4 [3];
	logic [63:0]        rh_d [3], rh_s4 [3];
	// stage 5
	logic               vld_s5, sep_s5;
	logic signed [100:0] pr_d [3][3], pr_s5 [3][3];
	logic [96:0]         rn_d [3], rn_s5 [3];
	// stage 6
	logic                vld_s6, sep_s6;
	logic signed [102:0] ps_d [3], ps_s6 [3];
	logic [98:0]         rs_d, rs_s6;
	// stage 7
	logic                done_s7, ovl_d, overlap_s7;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// box configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
			hx_q <= '0;
			hy_q <= '0;
			hz_q <= '0;
		end else if (wr_en) begin
			case (wr_idx)
				tbo_pkg::REG_CX: cx_q <= wr_data;
				tbo_pkg::REG_CY: cy_q <= wr_data;
				tbo_pkg::REG_CZ: cz_q <= wr_data;
				tbo_pkg::REG_HX: hx_q <= wr_data[30:0];
				tbo_pkg::REG_HY: hy_q <= wr_data[30:0];
				tbo_pkg::REG_HZ: hz_q <= wr_data[30:0];
				default: ;
			endcase
		end
	end

	// gather ports into arrays
	always_comb begin
		ctr[0] = cx_q; ctr[1] = cy_q; ctr[2] = cz_q;
		hlf[0] = hx_q; hlf[1] = hy_q; hlf[2] = hz_q;
		vin[0][0] = v0_x; vin[0][1] = v0_y; vin[0][2] = v0_z;
		vin[1][0] = v1_x; vin[1][1] = v1_y; vin[1][2] = v1_z;
		vin[2][0] = v2_x; vin[2][1] = v2_y; vin[2][2] = v2_z;
		off[0] = offset_x; off[1] = offset_y; off[2] = offset_z;
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			done_s7 <= 1'b0;
		end else begin
			vld_s1  <= accept;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			done_s7 <= vld_s6;
		end
	end

	// stage 1: box-local vertices, edges (offset and center cancel) and magnitudes
	always_comb begin
		logic signed [32:0] fp, fn;
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				v_d[k][i] = {{2{vin[k][i][31]}}, vin[k][i]}
					+ {{2{off[i][31]}}, off[i]} - {{2{ctr[i][31]}}, ctr[i]};
				fp = {vin[tbo_pkg::NXT[k]][i][31], vin[tbo_pkg::NXT[k]][i]}
					- {vin[k][i][31], vin[k][i]};
				fn = {vin[k][i][31], vin[k][i]}
					- {vin[tbo_pkg::NXT[k]][i][31], vin[tbo_pkg::NXT[k]][i]};
				f_d[k][i]  = fp;
				fa_d[k][i] = fp[32] ? fn : fp;
			end
		end
	end

	always_ff @(posedge clk) begin
		v_s1  <= v_d;
		f_s1  <= f_d;
		fa_s1 <= fa_d;
	end

	// stage 2: edge-axis products, normal products, box face test
	always_comb begin
		logic [34:0] ve, he, tg, tl;
		logic        ag, al;
		int          b, d, k;
		face_d = 1'b0;
		for (int j = 0; j < 3; j++) begin
			for (int a = 0; a < 3; a++) begin
				b = tbo_pkg::NXT[a];
				d = tbo_pkg::PRV[a];
				// edge start and far vertex; the edge end projects like its start
				for (int m = 0; m < 2; m++) begin
					k = (m == 0) ? j : tbo_pkg::PRV[j];
					pa_d[j][a][m] = tbo_pkg::mul_fv(f_s1[j][b], v_s1[k][d]);
					pb_d[j][a][m] = tbo_pkg::mul_fv(f_s1[j][d], v_s1[k][b]);
				end
				ra_d[j][a] = tbo_pkg::mul_hm(hlf[b], fa_s1[j][d]);
				rb_d[j][a] = tbo_pkg::mul_hm(hlf[d], fa_s1[j][b]);
			end
		end
		for (int a = 0; a < 3; a++) begin
			b = tbo_pkg::NXT[a];
			d = tbo_pkg::PRV[a];
			nm_d[a][0] = tbo_pkg::mul_ff(f_s1[0][b], f_s1[1][d]);
			nm_d[a][1] = tbo_pkg::mul_ff(f_s1[0][d], f_s1[1][b]);
			ag = 1'b1;
			al = 1'b1;
			for (int q = 0; q < 3; q++) begin
				ve = {v_s1[q][a][33], v_s1[q][a]};
				he = {4'b0, hlf[a]};
				tg = he - ve;
				tl = ve + he;
				ag = ag & tg[34];
				al = al & tl[34];
			end
			face_d = face_d | ag | al;
		end
	end

	always_ff @(posedge clk) begin
		v_s2    <= v_s1;
		pa_s2   <= pa_d;
		pb_s2   <= pb_d;
		ra_s2   <= ra_d;
		rb_s2   <= rb_d;
		nm_s2   <= nm_d;
		face_s2 <= face_d;
	end

	// stage 3: edge projections and radii, triangle normal and its magnitude
	always_comb begin
		logic signed [66:0] np, nn;
		for (int j = 0; j < 3; j++) begin
			for (int a = 0; a < 3; a++) begin
				for (int m = 0; m < 2; m++) begin
					ep_d[j][a][m] = {pa_s2[j][a][m][66], pa_s2[j][a][m]}
						- {pb_s2[j][a][m][66], pb_s2[j][a][m]};
				end
				er_d[j][a] = {1'b0, ra_s2[j][a]} + {1'b0, rb_s2[j][a]};
			end
		end
		for (int a = 0; a < 3; a++) begin
			np = {nm_s2[a][0][65], nm_s2[a][0]} - {nm_s2[a][1][65], nm_s2[a][1]};
			nn = {nm_s2[a][1][65], nm_s2[a][1]} - {nm_s2[a][0][65], nm_s2[a][0]};
			n_d[a]  = np;
			na_d[a] = np[66] ? nn[65:0] : np[65:0];
		end
	end

	always_ff @(posedge clk) begin
		v_s3    <= v_s2;
		ep_s3   <= ep_d;
		er_s3   <= er_d;
		n_s3    <= n_d;
		na_s3   <= na_d;
		face_s3 <= face_s2;
	end

	// stage 4: edge-axis compare, sliced normal products
	always_comb begin
		logic [68:0]        pe, re, tg, tl;
		logic               ag, al;
		logic signed [33:0] nl, nh;
		sep_d = face_s3;
		for (int j = 0; j < 3; j++) begin
			for (int a = 0; a < 3; a++) begin
				ag = 1'b1;
				al = 1'b1;
				for (int m = 0; m < 2; m++) begin
					pe = {ep_s3[j][a][m][67], ep_s3[j][a][m]};
					re = {4'b0, er_s3[j][a]};
					tg = re - pe;
					tl = pe + re;
					ag = ag & tg[68];
					al = al & tl[68];
				end
				sep_d = sep_d | ag | al;
			end
		end
		for (int a = 0; a < 3; a++) begin
			nl = {1'b0, n_s3[a][32:0]};
			nh = n_s3[a][66:33];
			for (int k = 0; k < 3; k++) begin
				ql_d[a][k] = tbo_pkg::mul_nv(nl, v_s3[k][a]);
				qh_d[a][k] = tbo_pkg::mul_nv(nh, v_s3[k][a]);
			end
			rl_d[a] = tbo_pkg::mul_hm(hlf[a], na_s3[a][32:0]);
			rh_d[a] = tbo_pkg::mul_hm(hlf[a], na_s3[a][65:33]);
		end
	end

	always_ff @(posedge clk) begin
		ql_s4  <= ql_d;
		qh_s4  <= qh_d;
		rl_s4  <= rl_d;
		rh_s4  <= rh_d;
		sep_s4 <= sep_d;
	end

	// stage 5: join the slices of each normal product
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			for (int k = 0; k < 3; k++) begin
				pr_d[a][k] = {qh_s4[a][k], 33'b0} + {{33{ql_s4[a][k][67]}}, ql_s4[a][k]};
			end
			rn_d[a] = {rh_s4[a], 33'b0} + {33'b0, rl_s4[a]};
		end
	end

	always_ff @(posedge clk) begin
		pr_s5  <= pr_d;
		rn_s5  <= rn_d;
		sep_s5 <= sep_s4;
	end

	// stage 6: normal projections of the vertices and normal radius
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ps_d[k] = {{2{pr_s5[0][k][100]}}, pr_s5[0][k]}
				+ {{2{pr_s5[1][k][100]}}, pr_s5[1][k]}
				+ {{2{pr_s5[2][k][100]}}, pr_s5[2][k]};
		end
		rs_d = {2'b0, rn_s5[0]} + {2'b0, rn_s5[1]} + {2'b0, rn_s5[2]};
	end

	always_ff @(posedge clk) begin
		ps_s6  <= ps_d;
		rs_s6  <= rs_d;
		sep_s6 <= sep_s5;
	end

	// stage 7: normal-axis compare, merge with earlier axes
	always_comb begin
		logic [103:0] pe, re, tg, tl;
		logic         ag, al;
		ag = 1'b1;
		al = 1'b1;
		for (int k = 0; k < 3; k++) begin
			pe = {ps_s6[k][102], ps_s6[k]};
			re = {5'b0, rs_s6};
			tg = re - pe;
			tl = pe + re;
			ag = ag & tg[103];
			al = al & tl[103];
		end
		ovl_d = ~(sep_s6 | ag | al);
	end

	always_ff @(posedge clk) begin
		overlap_s7 <= ovl_d;
	end

	assign done    = done_s7;
	assign overlap = overlap_s7;

endmodule

FILE: rtl/core/tbo_check.sv
// ----------------------------------------------------------------------------
// tbo_check: port-level checks for triangle_box_overlap_test
// Watches the command and result strobes for fixed latency and word count.
// ----------------------------------------------------------------------------
module tbo_check (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// every accepted word is answered by a done strobe
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##7 done)
		else $error("result word missing at fixed latency");

	// no result word without an accepted command word
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 7))
		else $error("result word without a command word");

	// the pipeline never refuses a command word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("command word refused");

endmodule

bind triangle_box_overlap_test tbo_check u_tbo_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
